>>> sv/f2i_pkg.sv
package f2i_pkg;

  localparam int unsigned OpW = 64;

  typedef struct packed {
    logic       nan;
    logic       huge;
    logic       neg;
    logic       uns;
    logic       dst64;
    logic [6:0] sh;
    logic       left;
    logic       zero;
    logic [52:0] m;
  } f2i_dec_t;

  typedef struct packed {
    logic       nan;
    logic       huge;
    logic       neg;
    logic       uns;
    logic       dst64;
    logic [63:0] mag;
  } f2i_mag_t;

endpackage

>>> sv/f2i_decode.sv
module f2i_decode import f2i_pkg::*; (
  input  logic [2:0]     kind_i,
  input  logic [OpW-1:0] operand_bits_i,
  output f2i_dec_t       dec_o
);

  logic [10:0] ex;
  logic [51:0] fr;
  logic [11:0] e;

  always_comb begin
    dec_o = '0;
    dec_o.uns = kind_i[0];
    dec_o.dst64 = kind_i[2];
    if (kind_i[1]) begin
      ex = operand_bits_i[62:52];
      fr = operand_bits_i[51:0];
      dec_o.neg = operand_bits_i[63];
      dec_o.nan = (ex == 11'h7FF) && (fr != '0);
      dec_o.huge = (ex == 11'h7FF) && (fr == '0);
      e = {1'b0, ex} - 12'd1023;
    end else begin
      ex = {3'b0, operand_bits_i[30:23]};
      fr = {operand_bits_i[22:0], 29'b0};
      dec_o.neg = operand_bits_i[31];
      dec_o.nan = (ex == 11'h0FF) && (fr != '0);
      dec_o.huge = (ex == 11'h0FF) && (fr == '0);
      e = {1'b0, ex} - 12'd127;
    end
    dec_o.m = {1'b1, fr};
    dec_o.zero = (ex == '0) || e[11];
    if (!dec_o.nan && !dec_o.huge && !dec_o.zero && (e >= 12'd64)) begin
      dec_o.huge = 1'b1;
    end
    dec_o.left = (e >= 12'd52);
    dec_o.sh = dec_o.left ? 7'(e - 12'd52) : 7'(12'd52 - e);
  end

endmodule

>>> sv/f2i_shift.sv
module f2i_shift import f2i_pkg::*; (
  input  f2i_dec_t dec_i,
  output f2i_mag_t mag_o
);

  logic [63:0] m64;

  always_comb begin
    m64 = {11'b0, dec_i.m};
    mag_o.nan = dec_i.nan;
    mag_o.huge = dec_i.huge;
    mag_o.neg = dec_i.neg;
    mag_o.uns = dec_i.uns;
    mag_o.dst64 = dec_i.dst64;
    if (dec_i.zero || dec_i.huge || dec_i.nan) begin
      mag_o.mag = '0;
    end else if (dec_i.left) begin
      mag_o.mag = m64 << dec_i.sh;
    end else begin
      mag_o.mag = m64 >> dec_i.sh;
    end
  end

endmodule

>>> sv/f2i_clamp.sv
module f2i_clamp import f2i_pkg::*; (
  input  f2i_mag_t       mag_i,
  output logic [OpW-1:0] result_o
);

  logic [63:0] umax;
  logic [63:0] pmax;
  logic [63:0] nlim;
  logic [63:0] mg;

  always_comb begin
    umax = mag_i.dst64 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    pmax = mag_i.dst64 ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
    nlim = pmax + 64'd1;
    mg = mag_i.mag;
    if (mag_i.nan) begin
      result_o = '0;
    end else if (mag_i.uns) begin
      if (mag_i.neg) begin
        result_o = '0;
      end else if (mag_i.huge || (mg > umax)) begin
        result_o = umax;
      end else begin
        result_o = mg;
      end
    end else begin
      if (mag_i.neg) begin
        if (mag_i.huge || (mg > nlim)) begin
          mg = nlim;
        end
        result_o = 64'd0 - mg;
      end else begin
        if (mag_i.huge || (mg > pmax)) begin
          mg = pmax;
        end
        result_o = mg;
      end
      if (!mag_i.dst64) begin
        result_o[63:32] = '0;
      end
    end
  end

endmodule

>>> sv/float_to_int_saturating_truncate_unit.sv
// Start shifts through the valid bits vld_q; done_o is their top bit.
// Throughput: one conversion per cycle; busy is always low.
// Stages: field decode, significand shift, range clamp, each registered.
// Reset clears the stage valid bits only; the receiver cannot stall.
module float_to_int_saturating_truncate_unit import f2i_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [2:0]     kind_i,
  input  logic [OpW-1:0] operand_bits_i,
  output logic           done_o,
  output logic [OpW-1:0] result_bits_o
);

  f2i_dec_t       dec_d, dec_q;
  f2i_mag_t       mag_d, mag_q;
  logic [OpW-1:0] res_d, res_q;
  logic [2:0]     vld_q;

  assign busy_o = 1'b0;

  f2i_decode u_dec (.kind_i(kind_i), .operand_bits_i(operand_bits_i), .dec_o(dec_d));
  f2i_shift  u_sh  (.dec_i(dec_q), .mag_o(mag_d));
  f2i_clamp  u_cl  (.mag_i(mag_q), .result_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    mag_q <= mag_d;
    res_q <= res_d;
  end

  assign done_o = vld_q[2];
  assign result_bits_o = res_q;

endmodule

>>> tb/f2i_checker.sv
`timescale 1ns / 100ps
module f2i_checker import f2i_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  logic [2:0]     kind_i,
  input  logic [OpW-1:0] operand_bits_i,
  input  logic           done_i,
  input  logic [OpW-1:0] result_bits_i,
  output int             errors_o,
  output int             pending_o
);

  logic [OpW-1:0] expected_results[$];

  function automatic logic [63:0] truncate_saturate(logic [2:0] kind, logic [63:0] bits);
    logic          uns;
    logic          src64;
    logic          dst64;
    logic          neg;
    logic          huge;
    logic          nan;
    logic          tiny;
    int            e;
    logic [63:0]   m;
    logic [63:0]   mag;
    logic [63:0]   lim;
    logic [63:0]   res;
    uns = kind[0];
    src64 = kind[1];
    dst64 = kind[2];
    huge = 1'b0;
    nan = 1'b0;
    tiny = 1'b0;
    e = 0;
    m = '0;
    mag = '0;
    if (src64) begin
      neg = bits[63];
      if (bits[62:52] == 11'h7ff) begin
        nan = bits[51:0] != 0;
        huge = !nan;
      end else if (bits[62:52] == 0) begin
        tiny = 1'b1;
      end else begin
        e = int'(bits[62:52]) - 1023;
        m = {11'd0, 1'b1, bits[51:0]};
      end
    end else begin
      neg = bits[31];
      if (bits[30:23] == 8'hff) begin
        nan = bits[22:0] != 0;
        huge = !nan;
      end else if (bits[30:23] == 0) begin
        tiny = 1'b1;
      end else begin
        e = int'(bits[30:23]) - 127;
        m = {11'd0, 1'b1, bits[22:0], 29'd0};
      end
    end
    if (!nan && !huge && !tiny) begin
      if (e < 0) mag = '0;
      else if (e >= 64) huge = 1'b1;
      else if (e >= 52) mag = m << (e - 52);
      else mag = m >> (52 - e);
    end
    if (nan) begin
      res = '0;
    end else if (uns) begin
      lim = dst64 ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
      if (neg) res = '0;
      else if (huge || mag > lim) res = lim;
      else res = mag;
    end else begin
      lim = dst64 ? 64'h7fff_ffff_ffff_ffff : 64'h0000_0000_7fff_ffff;
      if (neg) begin
        if (huge || mag > lim + 1) mag = lim + 1;
        res = -mag;
      end else begin
        if (huge || mag > lim) mag = lim;
        res = mag;
      end
      if (!dst64) res[63:32] = '0;
    end
    return res;
  endfunction

  assign pending_o = expected_results.size();

  initial errors_o = 0;

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result_bits: unexpected result %h", result_bits_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (result_bits_i !== want) begin
            $error("result_bits: expected %h actual %h", want, result_bits_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) expected_results.push_back(truncate_saturate(kind_i, operand_bits_i));
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench import f2i_pkg::*;;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  logic [2:0]     kind;
  logic [OpW-1:0] operand_bits;
  logic           done;
  logic [OpW-1:0] result_bits;
  int             errors;
  int             pending;
  int             cycles;

  float_to_int_saturating_truncate_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .kind_i(kind), .operand_bits_i(operand_bits),
    .done_o(done), .result_bits_o(result_bits)
  );

  f2i_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .kind_i(kind), .operand_bits_i(operand_bits), .done_i(done),
    .result_bits_i(result_bits), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_conversion(logic [2:0] k, logic [63:0] b);
    start <= 1'b1;
    kind <= k;
    operand_bits <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause_line(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [63:0] random_operand(logic [2:0] k);
    logic [63:0] b;
    logic [63:0] hi;
    b = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: if (k[1]) b[62:52] = 11'd1023 + 11'($urandom_range(0, 70));
         else b = {hi[63:32], b[31], 8'd127 + 8'($urandom_range(0, 70)), b[22:0]};
      2: if (k[1]) b[62:52] = 11'd1023 + 11'($urandom_range(28, 66));
         else b = {hi[63:32], b[31], 8'd127 + 8'($urandom_range(28, 66)), b[22:0]};
      3: if (k[1]) b[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'd0;
         else b[30:23] = $urandom_range(0, 1) ? 8'hff : 8'd0;
      default: if (k[1]) b[62:52] = 11'd1023 + 11'($urandom_range(0, 40));
         else b = {hi[63:32], b[31], 8'd127 + 8'($urandom_range(0, 40)), b[22:0]};
    endcase
    return b;
  endfunction

  initial begin
    logic [63:0] directed[$];
    int          burst;
    logic [2:0]  k_rand;
    start = 1'b0;
    kind = '0;
    operand_bits = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed = '{64'h0, 64'h8000_0000_8000_0000, 64'h7ff8_0000_7fc0_0001,
      64'hfff0_0000_ff80_0000, 64'h7ff0_0000_7f80_0000, 64'h43e0_0000_4f00_0000,
      64'hc3e0_0000_cf00_0000, 64'h41df_ffff_ffc0_0000, 64'hc1e0_0000_0020_0000,
      64'h3fef_ffff_3f7f_ffff, 64'h000f_ffff_007f_ffff, 64'hffff_ffff_bfc0_0000,
      64'h43f0_0000_5f80_0000, 64'h41ef_ffff_ffe0_0000};
    foreach (directed[i])
      for (int k = 0; k < 8; k++)
        if (i < 3 || k[0] == i[0]) send_conversion(3'(k), directed[i]);
    pause_line(1);
    wait (pending == 0);
    @(negedge clk);
    for (int n = 0; n < 1100; n += burst) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++) begin
        k_rand = 3'($urandom);
        send_conversion(k_rand, random_operand(k_rand));
      end
      pause_line($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
    end
    pause_line(1);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
